FILE: design/gda_pkg.sv
package gda_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned ADD_W   = 15;
    localparam int unsigned REM_W   = 16;

    localparam logic [YEAR_W-1:0]  MAX_YEAR   = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEAR_CYCLE = 14'd400;
    localparam logic [YEAR_W-1:0]  CYCLE_LAST = 14'd399;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_WALK,
        ST_DONE
    } gda_state_t;

    typedef struct packed {
        logic [ADD_W-1:0]   day_count;
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
    } gda_req_t;

    typedef struct packed {
        logic               year_overflow;
        logic [YEAR_W-1:0]  result_year;
        logic [MONTH_W-1:0] result_month;
        logic [DAY_W-1:0]   result_day;
    } gda_res_t;

    // leap from year mod 400
    function automatic logic is_leap(input logic [YEAR_W-1:0] r);
        logic by100;
        by100 = (r == 14'd100) || (r == 14'd200) || (r == 14'd300);
        return (r == '0) || ((r[1:0] == 2'b00) && !by100);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            4'd4:      len = 5'd30;
            4'd6:      len = 5'd30;
            4'd9:      len = 5'd30;
            4'd11:     len = 5'd30;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: design/gda_core.sv
module gda_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  gda_pkg::gda_req_t req,
    output logic              req_ready,
    output logic              res_valid,
    output gda_pkg::gda_res_t res,
    input  logic              res_ready
);

    gda_pkg::gda_state_t state_reg, state_next;

    logic [gda_pkg::REM_W-1:0]   rem_reg,   rem_next;
    logic [gda_pkg::MONTH_W-1:0] month_reg, month_next;
    logic [gda_pkg::YEAR_W-1:0]  year_reg,  year_next;
    logic [gda_pkg::YEAR_W-1:0]  mod_reg,   mod_next;
    logic                        ovf_reg,   ovf_next;

    logic [gda_pkg::DAY_W-1:0]   day_n;
    logic [gda_pkg::MONTH_W-1:0] month_n;
    logic [gda_pkg::YEAR_W-1:0]  year_n;
    logic [gda_pkg::DAY_W-1:0]   len;
    logic [gda_pkg::REM_W-1:0]   op_a, op_b;
    logic [gda_pkg::REM_W:0]     diff;
    logic                        a_le_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        mod_reg   <= mod_next;
        ovf_reg   <= ovf_next;
    end

    // input clean-up
    always_comb
    begin
        day_n   = (req.start_day == '0) ? 5'd1 : req.start_day;
        month_n = req.start_month;
        if (req.start_month == '0)
        begin
            month_n = gda_pkg::MONTH_JAN;
        end
        else if (req.start_month > gda_pkg::MONTH_DEC)
        begin
            month_n = gda_pkg::MONTH_DEC;
        end
        year_n  = (req.start_year == '0) ? 14'd1 : req.start_year;
    end

    // shared subtractor: year reduction by 400, then month lengths off the count
    assign len    = gda_pkg::month_len(month_reg, gda_pkg::is_leap(mod_reg));
    assign op_a   = (state_reg == gda_pkg::ST_MOD) ? {2'b00, mod_reg} : rem_reg;
    assign op_b   = (state_reg == gda_pkg::ST_MOD) ? {2'b00, gda_pkg::YEAR_CYCLE}
                                                   : {11'd0, len};
    assign diff   = {1'b0, op_a} - {1'b0, op_b};
    assign a_le_b = diff[gda_pkg::REM_W] || (diff == '0);

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        month_next = month_reg;
        year_next  = year_reg;
        mod_next   = mod_reg;
        ovf_next   = ovf_reg;
        req_ready  = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            gda_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    rem_next   = {11'd0, day_n} + {1'b0, req.day_count};
                    month_next = month_n;
                    year_next  = year_n;
                    mod_next   = year_n;
                    ovf_next   = (year_n > gda_pkg::MAX_YEAR);
                    state_next = ovf_next ? gda_pkg::ST_DONE : gda_pkg::ST_MOD;
                end
            end
            gda_pkg::ST_MOD:
            begin
                if (diff[gda_pkg::REM_W])
                begin
                    state_next = gda_pkg::ST_WALK;
                end
                else
                begin
                    mod_next = diff[gda_pkg::YEAR_W-1:0];
                end
            end
            gda_pkg::ST_WALK:
            begin
                if (a_le_b)
                begin
                    state_next = gda_pkg::ST_DONE;
                end
                else
                begin
                    rem_next = diff[gda_pkg::REM_W-1:0];
                    if (month_reg == gda_pkg::MONTH_DEC)
                    begin
                        month_next = gda_pkg::MONTH_JAN;
                        year_next  = year_reg + 14'd1;
                        mod_next   = (mod_reg == gda_pkg::CYCLE_LAST) ? '0 : mod_reg + 14'd1;
                        if (year_reg == gda_pkg::MAX_YEAR)
                        begin
                            ovf_next   = 1'b1;
                            state_next = gda_pkg::ST_DONE;
                        end
                    end
                    else
                    begin
                        month_next = month_reg + 4'd1;
                    end
                end
            end
            gda_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = gda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gda_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ovf_reg)
        begin
            res.result_day   = 5'd31;
            res.result_month = gda_pkg::MONTH_DEC;
            res.result_year  = gda_pkg::MAX_YEAR;
        end
        else
        begin
            res.result_day   = rem_reg[gda_pkg::DAY_W-1:0];
            res.result_month = month_reg;
            res.result_year  = year_reg;
        end
        res.year_overflow = ovf_reg;
    end

endmodule

FILE: design/gregorian_date_add_days.sv
// channel | dir | tdata (lsb first)                                    | tuser
// s_      | in  | start_day 5, start_month 4, start_year 14, days 15   | -
// m_      | out | result_day 5, result_month 4, result_year 14         | year_overflow
//
// A request first reduces its year modulo 400 and then walks month lengths off
// the day count, all through one shared subtractor; the month walk dominates.
// rst_n clears the sequencer and the output valid asynchronously.
// A result waits in the output register; the next request may run meanwhile
// and holds in its final state until that register is free.
module gregorian_date_add_days
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // start_day, start_month, start_year, day_count, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // result_day, result_month, result_year, pad
    output logic [0:0]  m_tuser   // year_overflow
);

    gda_pkg::gda_req_t req;
    gda_pkg::gda_res_t res;
    logic              res_valid;
    logic              res_ready;

    logic              m_tvalid_reg, m_tvalid_next;
    gda_pkg::gda_res_t out_reg;

    assign req = s_tdata[37:0];

    gda_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req       (req),
        .req_ready (s_tready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_reg.result_year, out_reg.result_month, out_reg.result_day};
    assign m_tuser  = out_reg.year_overflow;

endmodule

FILE: tb/gda_checker.sv
module gda_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [39:0]       s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [23:0]       m_tdata,
    input  logic [0:0]        m_tuser,
    output int unsigned       mismatches,
    output int unsigned       pending
);

    gda_pkg::gda_res_t expected_dates[$];

    function automatic bit year_is_leap(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        case (m)
            2:             return year_is_leap(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    function automatic gda_pkg::gda_res_t advance_date(input gda_pkg::gda_req_t r);
        int unsigned       day;
        int unsigned       mon;
        int unsigned       yr;
        int unsigned       remain;
        int unsigned       mo;
        gda_pkg::gda_res_t res;
        gda_pkg::gda_res_t sat;
        sat.result_day    = 5'd31;
        sat.result_month  = gda_pkg::MONTH_DEC;
        sat.result_year   = gda_pkg::MAX_YEAR;
        sat.year_overflow = 1'b1;
        day = r.start_day;
        mon = r.start_month;
        yr  = r.start_year;
        if (day == 0)
            day = 1;
        if (mon == 0)
            mon = 1;
        if (mon > 12)
            mon = 12;
        if (yr == 0)
            yr = 1;
        if (yr > gda_pkg::MAX_YEAR)
            return sat;
        remain = day;
        for (mo = 1; mo < mon; mo++)
            remain += month_days(mo, yr);
        remain += r.day_count;
        mo = 1;
        while (remain > month_days(mo, yr))
        begin
            remain -= month_days(mo, yr);
            mo++;
            if (mo > 12)
            begin
                mo = 1;
                yr++;
            end
        end
        if (yr > gda_pkg::MAX_YEAR)
            return sat;
        res.result_day    = remain[gda_pkg::DAY_W-1:0];
        res.result_month  = mo[gda_pkg::MONTH_W-1:0];
        res.result_year   = yr[gda_pkg::YEAR_W-1:0];
        res.year_overflow = 1'b0;
        return res;
    endfunction

    always @(posedge clk)
    begin
        gda_pkg::gda_res_t want;
        gda_pkg::gda_res_t got;
        if (!rst_n)
        begin
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_dates.push_back(advance_date(gda_pkg::gda_req_t'(s_tdata[37:0])));
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser[0], m_tdata[22:0]};
                if (expected_dates.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result %0d/%0d/%0d ovf %0b",
                                 got.result_day, got.result_month, got.result_year,
                                 got.year_overflow);
                    mismatches++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (got.result_day != want.result_day
                        || got.result_month != want.result_month
                        || got.result_year != want.result_year
                        || got.year_overflow != want.year_overflow)
                    begin
                        if (mismatches < 10)
                            $display({"mismatch: expected %0d/%0d/%0d ovf %0b, ",
                                      "got %0d/%0d/%0d ovf %0b"},
                                     want.result_day, want.result_month, want.result_year,
                                     want.year_overflow, got.result_day, got.result_month,
                                     got.result_year, got.year_overflow);
                        mismatches++;
                    end
                end
            end
            pending = expected_dates.size();
        end
    end

endmodule

FILE: tb/tb.sv
module tb;

    localparam int unsigned N_RANDOM   = 1000;
    localparam int unsigned N_CALM     = 150;
    localparam int unsigned LIMIT      = 6000000;
    localparam int unsigned DRAIN      = 1200;
    localparam int unsigned HOLD_OFF   = 3000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned reqs_sent;
    int unsigned cycles = 0;
    int unsigned idle_odds;
    bit          calm;
    bit          held;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    gregorian_date_add_days u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    gda_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic gda_pkg::gda_req_t date_req(input int unsigned d, input int unsigned m,
                                                   input int unsigned y, input int unsigned a);
        gda_pkg::gda_req_t r;
        r.start_day   = d[gda_pkg::DAY_W-1:0];
        r.start_month = m[gda_pkg::MONTH_W-1:0];
        r.start_year  = y[gda_pkg::YEAR_W-1:0];
        r.day_count   = a[gda_pkg::ADD_W-1:0];
        return r;
    endfunction

    function automatic gda_pkg::gda_req_t random_req();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0:       return date_req($urandom_range(0, 31), $urandom_range(0, 15),
                                     $urandom_range(0, 16383), $urandom_range(0, 32767));
            1:       return date_req($urandom_range(1, 31), $urandom_range(1, 12),
                                     $urandom_range(1, 9999), $urandom_range(0, 32767));
            2:       return date_req($urandom_range(1, 31), $urandom_range(1, 12),
                                     $urandom_range(9900, 9999), $urandom_range(0, 32767));
            default: return date_req($urandom_range(1, 28 + ($urandom_range(0, 3) == 0) * 3),
                                     $urandom_range(1, 12), $urandom_range(1, 9999),
                                     $urandom_range(0, ($urandom_range(0, 1) == 0) ? 60 : 1000));
        endcase
    endfunction

    // one request; returns at the falling edge after acceptance with tvalid still high
    task automatic send_req(input gda_pkg::gda_req_t r);
        s_tdata  <= {2'b00, r};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        reqs_sent++;
        @(negedge clk);
    endtask

    task automatic maybe_idle();
        if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7))
                @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("gregorian_date_add_days regression: fail");
            $finish;
        end
    end

    initial
    begin
        m_tready = 1'b0;
        held     = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held && reqs_sent >= 40)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF)
                    @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7))
                    @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        gda_pkg::gda_req_t directed[$];
        reqs_sent = 0;
        calm      = 1'b0;
        idle_odds = 3;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;

        directed.push_back(date_req(1, 1, 1, 0));
        directed.push_back(date_req(31, 12, 9999, 0));
        directed.push_back(date_req(31, 12, 9999, 1));
        directed.push_back(date_req(1, 1, 9999, 364));
        directed.push_back(date_req(1, 1, 9999, 365));
        directed.push_back(date_req(28, 2, 2000, 1));
        directed.push_back(date_req(28, 2, 1900, 1));
        directed.push_back(date_req(28, 2, 2024, 1));
        directed.push_back(date_req(28, 2, 2023, 1));
        directed.push_back(date_req(29, 2, 2024, 365));
        directed.push_back(date_req(31, 12, 2023, 1));
        directed.push_back(date_req(1, 1, 1, 32767));
        directed.push_back(date_req(15, 6, 9950, 32767));
        directed.push_back(date_req(0, 3, 2020, 0));
        directed.push_back(date_req(31, 2, 2021, 0));
        directed.push_back(date_req(31, 4, 2021, 5));
        directed.push_back(date_req(10, 0, 2020, 10));
        directed.push_back(date_req(5, 13, 2020, 3));
        directed.push_back(date_req(31, 15, 2019, 1));
        directed.push_back(date_req(1, 3, 0, 365));
        directed.push_back(date_req(1, 1, 10000, 0));
        directed.push_back(date_req(31, 15, 16383, 32767));
        directed.push_back(date_req(0, 0, 0, 0));

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            send_req(directed[i]);
            maybe_idle();
        end

        for (int unsigned i = 0; i < N_RANDOM; i++)
        begin
            if (i % 200 == 0)
                idle_odds = $urandom_range(0, 2) * 4;
            if (i == N_RANDOM - N_CALM)
                calm = 1'b1;
            send_req(random_req());
            maybe_idle();
        end
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN)
            @(posedge clk);
        if (mismatches == 0)
            $display("gregorian_date_add_days regression: pass");
        else
            $display("gregorian_date_add_days regression: fail");
        $finish;
    end

endmodule
